[rtl/tkt_pkg.sv]
// ----------------------------------------------------------------------------
// tkt_pkg
// Shared types and constants of the streaming top-k tracker.
// ----------------------------------------------------------------------------
package tkt_pkg;

  localparam int VALUE_W = 32;
  localparam int CFG_W   = 5;

  localparam logic [CFG_W-1:0] KEEP_COUNT_RESET = 5'd10;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [CFG_W-1:0]          keep_cfg_t;

endpackage

[rtl/tkt_sorted_store.sv]
// ----------------------------------------------------------------------------
// tkt_sorted_store
// Descending sorted register array. Each accepted word is compared against
// all held entries in parallel and inserted when it is accepted.
// ----------------------------------------------------------------------------
module tkt_sorted_store #(
  parameter int MAX_KEEP = 16,
  parameter int CNT_W    = $clog2(MAX_KEEP + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  tkt_pkg::value_t                     sample,
  input  logic                                stream_end,
  input  tkt_pkg::keep_cfg_t                  keep_count,
  output tkt_pkg::value_t [MAX_KEEP-1:0]      entries_next,
  output logic [CNT_W-1:0]                    count_next,
  output logic [CNT_W-1:0]                    count
);
  import tkt_pkg::*;

  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  value_t [MAX_KEEP-1:0] entries;
  logic   [CMP_W-1:0]    keep_ext;
  logic   [CNT_W-1:0]    keep_eff;
  logic   [CNT_W-1:0]    count_eff;
  logic   [CNT_W-1:0]    count_ins;
  logic   [MAX_KEEP-1:0] held;
  logic   [MAX_KEEP-1:0] beats;
  logic   [MAX_KEEP-1:0] slot;
  logic                  ins_en;

  // saturate k and cut the held set if k was lowered
  assign keep_ext  = CMP_W'(keep_count);
  assign keep_eff  = (keep_ext > CMP_W'(MAX_KEEP)) ? CNT_W'(MAX_KEEP) : CNT_W'(keep_ext);
  assign count_eff = (count > keep_eff) ? keep_eff : count;

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cmp
    assign held[i]  = CNT_W'(i) < count_eff;
    assign beats[i] = $signed(sample) > $signed(entries[i]);
    // free slots past the held ones count as insertion points
    assign slot[i]  = !held[i] || beats[i];
  end

  assign ins_en = (keep_eff != '0) && ((count_eff < keep_eff) || (|(beats & held)));

  always_comb begin
    count_ins = count_eff;
    if (ins_en && (count_eff < keep_eff)) begin
      count_ins = count_eff + CNT_W'(1);
    end
  end

  // shift down one place from the insertion point
  always_comb begin
    entries_next = entries;
    if (ins_en && slot[0]) begin
      entries_next[0] = sample;
    end
    for (int i = 1; i < MAX_KEEP; i++) begin
      if (ins_en && slot[i]) begin
        entries_next[i] = slot[i-1] ? entries[i-1] : sample;
      end
    end
  end

  assign count_next = count_ins;

  always_ff @(posedge clk) begin
    if (accept) begin
      entries <= entries_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= stream_end ? '0 : count_ins;
    end
  end

endmodule

[rtl/tkt_emitter.sv]
// ----------------------------------------------------------------------------
// tkt_emitter
// Output bank: takes a snapshot of the sorted store at stream end and
// shifts it out largest first, one word per handshake.
// ----------------------------------------------------------------------------
module tkt_emitter #(
  parameter int MAX_KEEP = 16,
  parameter int CNT_W    = $clog2(MAX_KEEP + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  tkt_pkg::value_t [MAX_KEEP-1:0] load_entries,
  input  logic [CNT_W-1:0]               load_count,
  output tkt_pkg::value_t                out_value,
  output logic                           out_valid,
  output logic                           out_final,
  input  logic                           out_ready,
  output logic                           busy,
  output logic                           done_now
);
  import tkt_pkg::*;

  value_t [MAX_KEEP-1:0] bank;
  logic   [CNT_W-1:0]    remaining;
  logic                  pop;

  assign out_valid = remaining != '0;
  assign out_final = remaining == CNT_W'(1);
  assign out_value = bank[0];
  assign busy      = out_valid;
  assign pop       = out_valid && out_ready;
  assign done_now  = pop && out_final;

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_bank
    always_ff @(posedge clk) begin
      if (load) begin
        bank[i] <= load_entries[i];
      end else if (pop) begin
        bank[i] <= (i == MAX_KEEP - 1) ? bank[i] : bank[(i + 1) % MAX_KEEP];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (load) begin
      remaining <= load_count;
    end else if (pop) begin
      remaining <= remaining - CNT_W'(1);
    end
  end

endmodule

[rtl/top_k_largest_tracker_top.sv]
// Timing: an input word is folded into the sorted store in the cycle it is
// accepted; results of a stream start in the cycle after its last word.
// Throughput: one input word per cycle; results leave at one word per cycle while m_tready is high.
// A last word waits only while the previous run is still being shifted out.
// Reset clears the held count and the output word count; keep_count returns to 10.
// ----------------------------------------------------------------------------
// top_k_largest_tracker_top
// Streaming top-k selection with a configurable keep count.
// ----------------------------------------------------------------------------
module top_k_largest_tracker_top #(
  parameter int MAX_KEEP = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [tkt_pkg::VALUE_W-1:0] s_tdata,   // [31:0] sample_value
  input  logic                        s_tlast,   // stream_end
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [tkt_pkg::VALUE_W-1:0] m_tdata,   // [31:0] ranked_value
  output logic                        m_tlast,   // final_rank
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tkt_pkg::CFG_W-1:0]   cfg_data   // [4:0] keep_count
);
  import tkt_pkg::*;

  localparam int CNT_W = $clog2(MAX_KEEP + 1);

  keep_cfg_t             keep_count;
  value_t [MAX_KEEP-1:0] entries_next;
  logic   [CNT_W-1:0]    count_next;
  logic   [CNT_W-1:0]    count;
  value_t                out_value;
  logic                  accept;
  logic                  load;
  logic                  busy;
  logic                  done_now;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KEEP_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      keep_count <= cfg_data;
    end
  end

  // hold a last word while the previous run is still draining
  assign s_tready = !busy || !s_tlast || done_now;
  assign accept   = s_tvalid && s_tready;
  assign load     = accept && s_tlast;

  tkt_sorted_store #(
    .MAX_KEEP (MAX_KEEP),
    .CNT_W    (CNT_W)
  ) u_store (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .sample       (value_t'(s_tdata)),
    .stream_end   (s_tlast),
    .keep_count   (keep_count),
    .entries_next (entries_next),
    .count_next   (count_next),
    .count        (count)
  );

  tkt_emitter #(
    .MAX_KEEP (MAX_KEEP),
    .CNT_W    (CNT_W)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .load_entries (entries_next),
    .load_count   (count_next),
    .out_value    (out_value),
    .out_valid    (m_tvalid),
    .out_final    (m_tlast),
    .out_ready    (m_tready),
    .busy         (busy),
    .done_now     (done_now)
  );

  assign m_tdata = out_value;

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (!busy || done_now))
    else $error("output bank loaded while a run is still draining");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    load |=> (count == '0))
    else $error("store not emptied after stream end");

  a_descending: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      ($signed(m_tdata) <= $signed($past(m_tdata))))
    else $error("results not in descending order");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    accept |-> (count_next <= CNT_W'(MAX_KEEP)))
    else $error("held count beyond store depth");
`endif

endmodule
